// ===== rtl/core/online_zscore_outlier_monitor_core_macros.svh =====
// assertion macros for the online z-score outlier monitor
// included by the modules that carry assertions; no other dependencies
`ifndef ONLINE_ZSCORE_OUTLIER_MONITOR_CORE_MACROS_SVH
`define ONLINE_ZSCORE_OUTLIER_MONITOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define OZM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OZM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OZM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OZM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ozm_pkg.sv =====
// shared types and constants for the online z-score outlier monitor
// no dependencies
package ozm_pkg;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam logic [15:0] ZLIMIT_RST = 16'd768;
    localparam logic [15:0] WARMUP_RST = 16'd30;
    localparam logic [0:0] REG_ZLIMIT = 1'b0;
    localparam logic [0:0] REG_WARMUP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_DIV,
        ST_PRE_SQRT,
        ST_TEST,
        ST_MEAN_DIV,
        ST_MEAN_UPD,
        ST_MUL,
        ST_ACC,
        ST_POST_DIV,
        ST_POST_SQRT,
        ST_OUT
    } ozm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic div_sd_start;
        logic div_mean_start;
        logic sqrt_start;
        logic test;
        logic mean_upd;
        logic mul_step;
        logic acc;
        logic out_load;
    } ozm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic mul_last;
        logic is_clear;
    } ozm_stat_t;
endpackage

// ===== rtl/core/ozm_datapath.sv =====
// datapath: welford state, shared divider, square root and multiplier
// depends on ozm_pkg and the assertion macro header
`include "online_zscore_outlier_monitor_core_macros.svh"
module ozm_datapath #(
    parameter int SAMPLE_WIDTH = ozm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ozm_pkg::ozm_cmd_t       cmd,
    output ozm_pkg::ozm_stat_t      stat,
    input  logic                    in_action,
    input  logic [31:0]             in_sample,
    input  logic [15:0]             zlimit,
    input  logic [15:0]             warmup,
    output logic                    outlier,
    output logic [31:0]             mean_now,
    output logic [31:0]             deviation_now,
    output logic [31:0]             count_now
);
    import ozm_pkg::*;

    // statistics
    logic [31:0]        count_reg, count_next;
    logic signed [47:0] mean_reg, mean_next;
    logic [63:0]        m2_reg, m2_next;
    // item registers
    logic               act_reg;
    logic signed [49:0] xq_reg;
    logic signed [49:0] delta_reg;
    logic [49:0]        adelta_reg;
    logic [49:0]        adelta2_reg;
    logic               flag_reg;
    logic [31:0]        sd_reg;

    // divider: 64 by 32 unsigned, one bit a cycle
    logic [63:0] dv_q_reg;
    logic [32:0] dv_r_reg;
    logic [31:0] dv_d_reg;
    logic [6:0]  dv_cnt_reg;
    logic        dv_busy_reg;
    logic [32:0] dv_rs;
    logic [32:0] dv_sub;

    // square root: 64 bit radicand, two bits a cycle
    logic [63:0] sq_v_reg;
    logic [63:0] sq_res_reg;
    logic [63:0] sq_bit_reg;
    logic        sq_busy_reg;
    logic [63:0] sq_trial;

    // multiplier: 50x50 split into 25 bit partial products
    logic [1:0]  mu_idx_reg;
    logic [99:0] mu_acc_reg;
    logic [24:0] mu_a, mu_b;
    logic [49:0] mu_pp;
    logic [99:0] mu_pp_sh;

    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [49:0] div_sgn;
    logic [49:0] new_x_diff;
    logic [67:0] m2_prod;
    logic [64:0] m2_sum;
    logic [55:0] lim;
    logic [63:0] dv_dividend;
    logic [31:0] dv_divisor;

    assign smp = SAMPLE_WIDTH'(in_sample);

    // divider inputs: sd uses m2/(n-1), mean uses |delta|/n
    always_comb
    begin
        if (cmd.div_mean_start)
        begin
            dv_dividend = 64'(adelta_reg);
            dv_divisor  = count_reg;
        end
        else
        begin
            dv_dividend = m2_reg;
            dv_divisor  = count_reg - 32'd1;
        end
    end

    assign dv_rs  = {dv_r_reg[31:0], dv_q_reg[63]};
    assign dv_sub = dv_rs - {1'b0, dv_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= 7'd0;
        end
        else if (cmd.div_sd_start || cmd.div_mean_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 7'd64;
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - 7'd1;
            if (dv_cnt_reg == 7'd1)
            begin
                dv_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_sd_start || cmd.div_mean_start)
        begin
            dv_q_reg <= dv_dividend;
            dv_r_reg <= 33'd0;
            dv_d_reg <= dv_divisor;
        end
        else if (dv_busy_reg)
        begin
            if (!dv_sub[32])
            begin
                dv_r_reg <= dv_sub;
                dv_q_reg <= {dv_q_reg[62:0], 1'b1};
            end
            else
            begin
                dv_r_reg <= dv_rs;
                dv_q_reg <= {dv_q_reg[62:0], 1'b0};
            end
        end
    end

    // square root of the divider quotient
    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
        end
        else if (sq_busy_reg && (sq_bit_reg[1:0] != 2'd0))
        begin
            sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_v_reg   <= dv_q_reg;
            sq_res_reg <= 64'd0;
            sq_bit_reg <= 64'd1 << 62;
        end
        else if (sq_busy_reg)
        begin
            if (sq_v_reg >= sq_trial)
            begin
                sq_v_reg   <= sq_v_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // multiplier partial products, one per cycle
    assign mu_a = mu_idx_reg[0] ? adelta_reg[49:25] : adelta_reg[24:0];
    assign mu_b = mu_idx_reg[1] ? adelta2_reg[49:25] : adelta2_reg[24:0];
    assign mu_pp = 50'(mu_a) * 50'(mu_b);
    always_comb
    begin
        case (mu_idx_reg)
            2'd0:    mu_pp_sh = 100'(mu_pp);
            2'd1:    mu_pp_sh = 100'(mu_pp) << 25;
            2'd2:    mu_pp_sh = 100'(mu_pp) << 25;
            default: mu_pp_sh = 100'(mu_pp) << 50;
        endcase
    end

    // mean step is sign applied truncated quotient
    assign div_sgn = delta_reg[49] ? -$signed(50'(dv_q_reg[49:0]))
                                   : $signed(50'(dv_q_reg[49:0]));
    assign new_x_diff = 50'(xq_reg - 50'(mean_next));
    assign m2_prod = mu_acc_reg[99:32];
    assign m2_sum = 65'(m2_reg) + 65'((m2_prod[67:64] != 4'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : m2_prod[63:0]);
    // threshold times sd, scaled from Q.24 up to Q.32
    assign lim = {48'(zlimit) * 48'(sd_reg), 8'd0};

    always_comb
    begin
        count_next = count_reg;
        mean_next  = mean_reg;
        m2_next    = m2_reg;
        if (cmd.clear)
        begin
            count_next = 32'd0;
            mean_next  = 48'sd0;
            m2_next    = 64'd0;
        end
        else if (cmd.mean_upd)
        begin
            mean_next = 48'(50'(mean_reg) + div_sgn);
        end
        else if (cmd.acc)
        begin
            m2_next = m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
        end
        else if (cmd.test && (count_reg != 32'hFFFF_FFFF))
        begin
            count_next = count_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 32'd0;
            mean_reg   <= 48'sd0;
            m2_reg     <= 64'd0;
            mu_idx_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            mean_reg  <= mean_next;
            m2_reg    <= m2_next;
            if (cmd.mean_upd)
            begin
                mu_idx_reg <= 2'd0;
            end
            else if (cmd.mul_step)
            begin
                mu_idx_reg <= mu_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_action;
            xq_reg    <= 50'(smp) <<< 16;
            delta_reg <= (50'(smp) <<< 16) - 50'(mean_reg);
            adelta_reg <= ((50'(smp) <<< 16) - 50'(mean_reg)) < 0
                ? 50'(-((50'(smp) <<< 16) - 50'(mean_reg)))
                : 50'((50'(smp) <<< 16) - 50'(mean_reg));
            flag_reg  <= 1'b0;
            sd_reg    <= 32'd0;
        end
        if (cmd.test)
        begin
            flag_reg <= (count_reg >= 32'(warmup)) && (count_reg >= 32'd2)
                        && (sd_reg != 32'd0) && (56'(adelta_reg) > lim);
        end
        if (cmd.sqrt_start)
        begin
            sd_reg <= 32'd0;
        end
        else if (sq_busy_reg && (sq_bit_reg[1:0] != 2'd0))
        begin
            sd_reg <= (count_reg >= 32'd2)
                ? ((sq_v_reg >= sq_trial) ? 32'((sq_res_reg >> 1) + sq_bit_reg)
                                          : 32'(sq_res_reg >> 1))
                : 32'd0;
        end
        if (cmd.mean_upd)
        begin
            adelta2_reg <= new_x_diff[49] ? 50'(-new_x_diff) : new_x_diff;
            mu_acc_reg  <= 100'd0;
        end
        else if (cmd.mul_step)
        begin
            mu_acc_reg <= mu_acc_reg + mu_pp_sh;
        end
        if (cmd.out_load)
        begin
            outlier       <= act_reg ? 1'b0 : flag_reg;
            mean_now      <= 32'(mean_reg >>> 16);
            deviation_now <= (count_reg >= 32'd2) ? sd_reg : 32'd0;
            count_now     <= count_reg;
        end
    end

    assign stat.busy     = dv_busy_reg || sq_busy_reg;
    assign stat.mul_last = (mu_idx_reg == 2'd3);
    assign stat.is_clear = act_reg;

    `OZM_ASSERT_NEXT(a_clear_zero, clk, rst_n, cmd.clear, (count_reg == 32'd0) && (m2_reg == 64'd0))
    `OZM_ASSERT_IMP(a_no_dual_unit, clk, rst_n, sq_busy_reg, !dv_busy_reg)
    `OZM_ASSERT_NEXT(a_count_mono, clk, rst_n, cmd.test && (count_reg != 32'd0), count_reg != 32'd0)
endmodule

// ===== rtl/core/ozm_ctrl.sv =====
// controller state machine sequencing one item through the datapath
// depends on ozm_pkg and the assertion macro header
`include "online_zscore_outlier_monitor_core_macros.svh"
module ozm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ozm_pkg::ozm_cmd_t   cmd,
    input  ozm_pkg::ozm_stat_t  stat
);
    import ozm_pkg::*;

    ozm_state_t state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       started_reg, started_next;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        started_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_PRE_DIV;
                end
            end
            ST_PRE_DIV:
            begin
                if (stat.is_clear)
                begin
                    state_next = ST_OUT;
                end
                else if (started_reg && !stat.busy)
                begin
                    state_next = ST_PRE_SQRT;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            ST_PRE_SQRT:
            begin
                if (started_reg && !stat.busy)
                begin
                    state_next = ST_TEST;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            ST_TEST:     state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:
            begin
                if (started_reg && !stat.busy)
                begin
                    state_next = ST_MEAN_UPD;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            ST_MEAN_UPD: state_next = ST_MUL;
            ST_MUL:
            begin
                if (stat.mul_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:      state_next = ST_POST_DIV;
            ST_POST_DIV:
            begin
                if (started_reg && !stat.busy)
                begin
                    state_next = ST_POST_SQRT;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            ST_POST_SQRT:
            begin
                if (started_reg && !stat.busy)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            ST_OUT:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:      cmd.load = in_valid && in_ready;
            ST_PRE_DIV:
            begin
                cmd.clear        = stat.is_clear;
                cmd.div_sd_start = !stat.is_clear && !started_reg;
            end
            ST_PRE_SQRT:  cmd.sqrt_start = !started_reg;
            ST_TEST:      cmd.test = 1'b1;
            ST_MEAN_DIV:  cmd.div_mean_start = !started_reg;
            ST_MEAN_UPD:  cmd.mean_upd = 1'b1;
            ST_MUL:       cmd.mul_step = 1'b1;
            ST_ACC:       cmd.acc = 1'b1;
            ST_POST_DIV:  cmd.div_sd_start = !started_reg;
            ST_POST_SQRT: cmd.sqrt_start = !started_reg;
            ST_OUT:       cmd.out_load = 1'b1;
            default:      cmd = '0;
        endcase
    end

    // result register handshake
    assign in_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if (state_reg == ST_OUT)
        begin
            ov_next = 1'b1;
        end
    end
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ov_reg      <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            started_reg <= started_next;
        end
    end

    `OZM_ASSERT_NEXT(a_out_set, clk, rst_n, state_reg == ST_OUT, out_valid)
    `OZM_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `OZM_ASSERT_IMP(a_one_start, clk, rst_n, cmd.div_sd_start, !cmd.sqrt_start)
endmodule

// ===== rtl/core/online_zscore_outlier_monitor_core.sv =====
// top level of the online z-score outlier monitor
// depends on ozm_pkg, ozm_ctrl and ozm_datapath
//
// usage: one item per in_valid/in_ready handshake; action 1 clears the
// statistics, action 0 observes a Q16.16 sample. each item yields one
// result on out_valid/out_ready: outlier flag, mean, deviation and count.
// configuration: cfg_we writes the z limit (index 0) or the warm-up count
// (index 1) from cfg_data; other indexes are ignored.
// a sample runs through the shared one-bit-a-cycle 64 bit divider and
// the 32 step square root, the test, a second divider pass and the mean
// update, a 4 step multiply and accumulate, a third divider pass and the
// square root, and the output. a clear skips the arithmetic and goes
// straight to the output. one item is worked on at a time.
// reset clears the statistics and loads 3.0 and 30 into the registers.
// a stalled receiver holds the result; the next item is taken as soon
// as the previous result is taken or in the same cycle it is.
module online_zscore_outlier_monitor_core #(
    parameter int SAMPLE_WIDTH = ozm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        outlier,
    output logic [31:0] mean_now,
    output logic [31:0] deviation_now,
    output logic [31:0] count_now,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ozm_pkg::*;

    ozm_cmd_t    cmd;
    ozm_stat_t   stat;
    logic [15:0] zlimit_reg;
    logic [15:0] warmup_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zlimit_reg <= ZLIMIT_RST;
            warmup_reg <= WARMUP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZLIMIT: zlimit_reg <= cfg_data;
                REG_WARMUP: warmup_reg <= cfg_data;
                default:    zlimit_reg <= zlimit_reg;
            endcase
        end
    end

    ozm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ozm_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_action     (action),
        .in_sample     (sample),
        .zlimit        (zlimit_reg),
        .warmup        (warmup_reg),
        .outlier       (outlier),
        .mean_now      (mean_now),
        .deviation_now (deviation_now),
        .count_now     (count_now)
    );
endmodule

// ===== bench/online_zscore_outlier_monitor_core_test.sv =====
// self-checking bench for the online z-score outlier monitor core
// depends on ozm_pkg and online_zscore_outlier_monitor_core
// a Welford predictor follows each accepted item and checks every result field
`timescale 1ns / 1ps

module online_zscore_outlier_monitor_core_test;
    import ozm_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic        act;
        logic [31:0] smp;
    } sample_item_t;

    typedef struct {
        logic        flag;
        logic [31:0] mean;
        logic [31:0] dev;
        logic [31:0] cnt;
    } stats_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [31:0] sample = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        outlier;
    logic [31:0] mean_now;
    logic [31:0] deviation_now;
    logic [31:0] count_now;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_ZLIMIT;
    logic [15:0] cfg_data = '0;

    online_zscore_outlier_monitor_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .sample(sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .outlier(outlier),
        .mean_now(mean_now),
        .deviation_now(deviation_now),
        .count_now(count_now),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state and register copies
    logic [15:0]  thr_q88 = ZLIMIT_RST;
    logic [15:0]  min_count = WARMUP_RST;
    logic [31:0]  n_seen = '0;
    longint       mean_q32 = 0;
    logic [63:0]  m2_sum = '0;

    sample_item_t pending[$];
    stats_t       stats_due[$];
    int           errors = 0;
    bit           quiet = 1'b0;
    bit           hold_go = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_left = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           cycles = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] std_q16();
        if (n_seen < 2)
            return '0;
        return root_floor(m2_sum / {32'b0, n_seen - 32'd1}) & 64'h0000_0000_FFFF_FFFF;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // welford update for one accepted item, queues the expected statistics
    task automatic predict_stats(input logic act, input logic [31:0] smp);
        longint       xq;
        longint       dl;
        longint       dl2;
        logic [63:0]  sd;
        logic [63:0]  lim;
        logic [127:0] prod;
        logic [64:0]  acc;
        logic [63:0]  inc;
        stats_t       r;
        if (act)
        begin
            n_seen = '0;
            mean_q32 = 0;
            m2_sum = '0;
            r = '{1'b0, 32'd0, 32'd0, 32'd0};
        end
        else
        begin
            xq = longint'($signed(smp)) * 65536;
            dl = xq - mean_q32;
            r.flag = 1'b0;
            if (n_seen >= {16'b0, min_count} && n_seen >= 2)
            begin
                sd = std_q16();
                if (sd != 0)
                begin
                    lim = ({48'b0, thr_q88} * sd) << 8;
                    r.flag = magnitude(dl) > lim;
                end
            end
            if (n_seen != 32'hFFFF_FFFF)
                n_seen = n_seen + 32'd1;
            mean_q32 = mean_q32 + dl / longint'({32'b0, n_seen});
            dl2 = xq - mean_q32;
            prod = {64'b0, magnitude(dl)} * {64'b0, magnitude(dl2)};
            prod = prod >> 32;
            inc = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
            acc = {1'b0, m2_sum} + {1'b0, inc};
            m2_sum = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
            r.mean = mean_q32[47:16];
            r.dev = 32'(std_q16());
            r.cnt = n_seen;
        end
        stats_due = {stats_due, r};
    endtask

    // sender: holds each item until taken, random gaps between items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_stats(action, sample);
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    action <= pending[0].act;
                    sample <= pending[0].smp;
                    void'(pending.pop_front());
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started once
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (stats_due.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: result with nothing expected, actual %0d %h %h %0d",
                             $time, outlier, mean_now, deviation_now, count_now);
                end
                else
                begin
                    if (outlier !== stats_due[0].flag)
                    begin
                        errors = errors + 1;
                        $display("%0t: outlier expected %0d actual %0d",
                                 $time, stats_due[0].flag, outlier);
                    end
                    if (mean_now !== stats_due[0].mean)
                    begin
                        errors = errors + 1;
                        $display("%0t: mean_now expected %h actual %h",
                                 $time, stats_due[0].mean, mean_now);
                    end
                    if (deviation_now !== stats_due[0].dev)
                    begin
                        errors = errors + 1;
                        $display("%0t: deviation_now expected %h actual %h",
                                 $time, stats_due[0].dev, deviation_now);
                    end
                    if (count_now !== stats_due[0].cnt)
                    begin
                        errors = errors + 1;
                        $display("%0t: count_now expected %0d actual %0d",
                                 $time, stats_due[0].cnt, count_now);
                    end
                    void'(stats_due.pop_front());
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (hold_left > 1 || (hold_go && !hold_done))
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    recv_gap <= $urandom_range(1, 3);
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_item(input logic act, input logic [31:0] smp);
        sample_item_t it;
        it.act = act;
        it.smp = smp;
        pending = {pending, it};
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_ZLIMIT)
            thr_q88 = val;
        else
            min_count = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || in_valid || stats_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // noisy series around a level, with spikes, clears and raw values
    task automatic add_random(input int count);
        logic [31:0] level;
        int          pick;
        level = $urandom();
        level = {{8{level[31]}}, level[31:8]};
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                add_item(1'b1, $urandom());
            else if (pick < 72)
                add_item(1'b0, level + $urandom_range(0, 65536) - 32768);
            else if (pick < 82)
                add_item(1'b0, level + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
            else if (pick < 93)
                add_item(1'b0, $urandom());
            else if (pick < 96)
                add_item(1'b0, level);
            else
            begin
                add_item(1'b0, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
                level = $urandom();
                level = {{8{level[31]}}, level[31:8]};
            end
        end
    endtask

    // stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clear, constant series, spike after warm-up
        add_item(1'b1, 32'h0);
        add_item(1'b0, 32'h7FFF_FFFF);
        add_item(1'b0, 32'h8000_0000);
        add_item(1'b0, 32'h7FFF_FFFF);
        add_item(1'b0, 32'h8000_0000);
        add_item(1'b0, 32'h7FFF_FFFF);
        add_item(1'b0, 32'hFFFF_FFFF);
        add_item(1'b1, 32'hFFFF_FFFF);
        add_item(1'b0, 32'h0);
        for (int i = 0; i < 5; i++)
            add_item(1'b0, 32'h0001_0000);
        add_item(1'b1, 32'h5555_5555);
        wait_drained();
        write_reg(REG_WARMUP, 16'd0);
        add_item(1'b0, 32'h0001_0000);
        add_item(1'b0, 32'h0002_0000);
        add_item(1'b0, 32'h0001_8000);
        add_item(1'b0, 32'h0001_4000);
        add_item(1'b0, 32'h0100_0000);
        add_item(1'b0, 32'hFF00_0000);
        add_item(1'b0, 32'h0001_0000);
        wait_drained();

        write_reg(REG_ZLIMIT, 16'h0100);
        add_random(400);
        wait_drained();

        write_reg(REG_ZLIMIT, 16'h0000);
        write_reg(REG_WARMUP, 16'd1);
        add_random(300);
        wait_drained();

        write_reg(REG_ZLIMIT, 16'hFFFF);
        write_reg(REG_WARMUP, 16'hFFFF);
        add_random(200);
        wait_drained();

        // receiver holds off while items keep coming
        write_reg(REG_ZLIMIT, 16'd768);
        write_reg(REG_WARMUP, 16'd2);
        add_random(300);
        hold_go = 1'b1;
        wait_drained();

        // last part runs without idling
        write_reg(REG_ZLIMIT, 16'h0180);
        write_reg(REG_WARMUP, 16'd5);
        quiet = 1'b1;
        add_random(330);
        wait_drained();
        repeat (300) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
